>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/core/smsort_pkg.sv
// ----------------------------------------------------------------------------
// smsort_pkg
// shared types and constants of the stable merge sorter
// ----------------------------------------------------------------------------
package smsort_pkg;

    localparam int KEY_BITS      = 32;
    localparam int TAG_BITS      = 16;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                last;
    } t_in_beat;

    typedef struct packed {
        logic [KEY_BITS-1:0] sorted_key;
        logic [TAG_BITS-1:0] sorted_tag;
        logic                final_res;
        logic                overflow;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_MERGE,
        ST_DRAIN_RD,
        ST_DRAIN_LD
    } t_state;

endpackage

>>> rtl/core/stable_merge_sort.sv
// ----------------------------------------------------------------------------
// stable_merge_sort
// batch sorter: stable ascending bottom-up merge sort on a key with a tag
// ----------------------------------------------------------------------------
// Items load one per cycle into bank 0 of a two-bank RAM until the beat marked
// last; beats past MAX_ITEMS are dropped and flag the batch as overflowed. A
// batch of n items then takes ceil(log2 n) merge passes, in which one shared
// comparator picks the next item from two run heads and writes it to the other
// bank; then each result is read from RAM and loaded into the output register,
// waiting while the output stalls. Throughput is bounded by the single
// comparator and the RAM write port. Input stalls from the closing beat until
// the last result is in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_merge_sort #(
    parameter int MAX_ITEMS = smsort_pkg::MAX_ITEMS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  smsort_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output smsort_pkg::t_out_beat o_out_data
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int AW    = IDX_W + 1;
    localparam int CW    = IDX_W + 2;
    localparam int KB    = smsort_pkg::KEY_BITS;
    localparam int DW    = smsort_pkg::KEY_BITS + smsort_pkg::TAG_BITS;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    smsort_pkg::t_state    r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_ovf, n_ovf;
    logic                  r_src, n_src;
    logic [CW-1:0]         r_w, n_w;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_i, n_i;
    logic [CW-1:0]         r_iend, n_iend;
    logic [CW-1:0]         r_j, n_j;
    logic [CW-1:0]         r_jend, n_jend;
    logic [CW-1:0]         r_k, n_k;
    logic                  r_out_valid, n_out_valid;
    smsort_pkg::t_out_beat r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [DW-1:0] rdata_a;
    logic [DW-1:0] rdata_b;

    logic          take_left;
    logic          out_free;
    logic [CW-1:0] w2;
    logic [CW-1:0] w4;
    logic [CW-1:0] lo_next;

    function automatic logic [CW-1:0] f_min(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    smsort_ram #(
        .WIDTH (DW),
        .DEPTH (2 ** AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // left run holds the earlier items, so ties go left
    assign take_left = (r_i < r_iend) &&
                       (!(r_j < r_jend) || (rdata_a[DW-1 -: KB] <= rdata_b[DW-1 -: KB]));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign w2        = {r_w[CW-2:0], 1'b0};
    assign w4        = {w2[CW-2:0], 1'b0};
    assign lo_next   = r_lo + w2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smsort_pkg::ST_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_w    <= n_w;
        r_lo   <= n_lo;
        r_i    <= n_i;
        r_iend <= n_iend;
        r_j    <= n_j;
        r_jend <= n_jend;
        r_k    <= n_k;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_src       = r_src;
        n_w         = r_w;
        n_lo        = r_lo;
        n_i         = r_i;
        n_iend      = r_iend;
        n_j         = r_j;
        n_jend      = r_jend;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we          = 1'b0;
        waddr       = {1'b0, r_cnt[IDX_W-1:0]};
        wdata       = {i_in_data.key, i_in_data.tag};
        raddr_a     = {r_src, r_i[IDX_W-1:0]};
        raddr_b     = {r_src, r_j[IDX_W-1:0]};

        case (r_state)
            smsort_pkg::ST_LOAD: begin
                if (i_in_valid) begin
                    if (r_cnt < MAX_C) begin
                        we    = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        n_src = 1'b0;
                        n_k   = '0;
                        if (n_cnt <= CW'(1)) begin
                            n_state = smsort_pkg::ST_DRAIN_RD;
                        end else begin
                            n_w     = CW'(1);
                            n_lo    = '0;
                            n_i     = '0;
                            n_iend  = CW'(1);
                            n_j     = CW'(1);
                            n_jend  = f_min(CW'(2), n_cnt);
                            n_state = smsort_pkg::ST_PRIME;
                        end
                    end
                end
            end
            smsort_pkg::ST_PRIME: begin
                // run heads are being read, first compare next cycle
                n_state = smsort_pkg::ST_MERGE;
            end
            smsort_pkg::ST_MERGE: begin
                we    = 1'b1;
                waddr = {~r_src, r_k[IDX_W-1:0]};
                wdata = take_left ? rdata_a : rdata_b;
                n_k   = r_k + CW'(1);
                if (take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                if ((n_i >= r_iend) && (n_j >= r_jend)) begin
                    if (lo_next >= r_cnt) begin
                        // pass done, the written bank becomes the source
                        n_src = ~r_src;
                        n_w   = w2;
                        n_k   = '0;
                        if (w2 >= r_cnt) begin
                            n_state = smsort_pkg::ST_DRAIN_RD;
                        end else begin
                            n_lo    = '0;
                            n_i     = '0;
                            n_iend  = f_min(w2, r_cnt);
                            n_j     = w2;
                            n_jend  = f_min(w4, r_cnt);
                            n_state = smsort_pkg::ST_PRIME;
                        end
                    end else begin
                        n_lo   = lo_next;
                        n_i    = lo_next;
                        n_iend = f_min(lo_next + r_w, r_cnt);
                        n_j    = lo_next + r_w;
                        n_jend = f_min(lo_next + w2, r_cnt);
                    end
                end
                raddr_a = {r_src, n_i[IDX_W-1:0]};
                raddr_b = {r_src, n_j[IDX_W-1:0]};
            end
            smsort_pkg::ST_DRAIN_RD: begin
                raddr_a = {r_src, r_k[IDX_W-1:0]};
                n_state = smsort_pkg::ST_DRAIN_LD;
            end
            smsort_pkg::ST_DRAIN_LD: begin
                raddr_a = {r_src, r_k[IDX_W-1:0]};
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.sorted_key = rdata_a[DW-1 -: KB];
                    n_out.sorted_tag = rdata_a[DW-KB-1:0];
                    n_out.final_res  = (r_k + CW'(1) == r_cnt);
                    n_out.overflow   = r_ovf;
                    n_k              = r_k + CW'(1);
                    if (r_k + CW'(1) == r_cnt) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = smsort_pkg::ST_LOAD;
                    end else begin
                        n_state = smsort_pkg::ST_DRAIN_RD;
                    end
                end
            end
            default: begin
                n_state = smsort_pkg::ST_LOAD;
            end
        endcase
    end

    assign o_in_stall  = (r_state != smsort_pkg::ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_CLK(a_cnt_cap, r_cnt <= MAX_C, "item count above capacity")
    `ASSERT_CLK(a_merge_idx, (r_state == smsort_pkg::ST_MERGE) |-> (r_k < r_cnt), "merge write past batch")
    `ASSERT_CLK(a_merge_run, (r_state == smsort_pkg::ST_MERGE) |-> ((r_w < r_cnt) && (r_i <= r_iend)), "merge run bounds broken")
    `ASSERT_CLK(a_final_load, (r_out_valid && r_out.final_res && $rose(r_out_valid)) |-> (r_state == smsort_pkg::ST_LOAD), "final beat without batch end")
    `ASSERT_ALWAYS(a_reset, !i_rst_n |=> ((r_state == smsort_pkg::ST_LOAD) && !r_out_valid && (r_cnt == '0)), "reset did not clear control")

endmodule

>>> rtl/core/smsort_ram.sv
// ----------------------------------------------------------------------------
// smsort_ram
// generic ram, one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module smsort_ram #(
    parameter int WIDTH = smsort_pkg::KEY_BITS + smsort_pkg::TAG_BITS,
    parameter int DEPTH = 2 * smsort_pkg::MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> tb/tb_stable_merge_sort.sv
// ----------------------------------------------------------------------------
// tb_stable_merge_sort
// self-checking bench for the stable batch sorter
// ----------------------------------------------------------------------------
// Batches of keyed beats go in through a bursty driver. A behavioral copy of
// the sorter collects each batch, drops beats past capacity and sorts stably
// on the closing beat. A monitor checks every output beat field by field
// against the oldest predicted one. The directed batches cover single items,
// extreme keys, equal keys and reversed order. The random batches vary in
// size, include full and overflowing batches, and use key mixes that often
// repeat. The receiver stalls at random, and at times holds off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_stable_merge_sort;

    localparam int MAX_ITEMS = smsort_pkg::MAX_ITEMS_DEF;
    localparam int KEY_BITS = smsort_pkg::KEY_BITS;
    localparam int TAG_BITS = smsort_pkg::TAG_BITS;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;

    typedef enum int {
        KEYS_FULL,
        KEYS_FEW,
        KEYS_EDGE,
        KEYS_MIXED
    } t_key_mix;

    typedef struct {
        smsort_pkg::t_in_beat beat;
        bit                   drain_first;
    } t_send;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    smsort_pkg::t_in_beat  in_beat = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    smsort_pkg::t_out_beat out_beat;

    t_send                 send_queue[$];
    logic [KEY_BITS-1:0]   batch_keys[$];
    logic [TAG_BITS-1:0]   batch_tags[$];
    bit                    batch_dropped = 1'b0;
    smsort_pkg::t_out_beat sorted_results[$];
    bit                    results_clear = 1'b1;
    bit                    stim_done = 1'b0;
    int                    mismatches = 0;

    stable_merge_sort DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #(20 * 400000);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic [KEY_BITS-1:0] pick_key(t_key_mix mix);
        logic [KEY_BITS-1:0] k;
        k = $urandom;
        case (mix)
            KEYS_FEW: k = KEY_BITS'($urandom_range(0, 7));
            KEYS_EDGE: begin
                case ($urandom_range(0, 3))
                    0: k = '0;
                    1: k = '1;
                    2: k = {1'b1, {(KEY_BITS-1){1'b0}}};
                    default: k = {1'b0, {(KEY_BITS-1){1'b1}}};
                endcase
            end
            KEYS_MIXED: begin
                if ($urandom_range(0, 1) == 0) k = KEY_BITS'($urandom_range(0, 3));
            end
            default: ;
        endcase
        return k;
    endfunction

    task automatic push_item(logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag,
                             logic is_last, bit drain_first);
        t_send s;
        s.beat.key  = key;
        s.beat.tag  = tag;
        s.beat.last = is_last;
        s.drain_first = drain_first;
        send_queue.push_back(s);
    endtask

    task automatic queue_batch(int n, bit drain_first, t_key_mix mix);
        for (int i = 0; i < n; i++) begin
            push_item(pick_key(mix), TAG_BITS'($urandom), i == n - 1, drain_first && i == 0);
        end
    endtask

    initial begin
        int total;
        int idx;
        int n;

        // single-item batches at both extremes
        push_item('0, '0, 1'b1, 1'b0);
        push_item('1, '1, 1'b1, 1'b1);
        // equal keys must keep arrival order
        push_item(32'd7, 16'h0001, 1'b0, 1'b1);
        push_item(32'd3, 16'h0002, 1'b0, 1'b0);
        push_item(32'd7, 16'h0003, 1'b0, 1'b0);
        push_item(32'd3, 16'h0004, 1'b0, 1'b0);
        push_item(32'hFFFF_FFFF, 16'h0005, 1'b0, 1'b0);
        push_item(32'd0, 16'h0006, 1'b0, 1'b0);
        push_item(32'd3, 16'h0007, 1'b1, 1'b0);
        // reversed order
        push_item(32'hFFFF_FFFF, 16'hA000, 1'b0, 1'b0);
        push_item(32'h8000_0000, 16'hA001, 1'b0, 1'b0);
        push_item(32'h7FFF_FFFF, 16'hA002, 1'b0, 1'b0);
        push_item(32'd1, 16'hA003, 1'b0, 1'b0);
        push_item(32'd0, 16'hA004, 1'b1, 1'b0);
        // pair with equal keys
        push_item(32'hAAAA_5555, 16'h1234, 1'b0, 1'b0);
        push_item(32'hAAAA_5555, 16'h4321, 1'b1, 1'b0);

        // mostly small batches; one exactly full, one whose closing beat is dropped
        total = 0;
        idx = 0;
        while (total < 220 || idx < 8) begin
            if (idx == 3) n = MAX_ITEMS;
            else if (idx == 7) n = MAX_ITEMS + 1;
            else if ($urandom_range(0, 19) == 0) n = $urandom_range(MAX_ITEMS, MAX_ITEMS + 6);
            else n = $urandom_range(1, 12);
            queue_batch(n, $urandom_range(0, 4) == 0, t_key_mix'($urandom_range(0, 3)));
            total += n;
            idx++;
        end

        do @(posedge clk); while (!(stim_done && results_clear));
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: bursts with random gaps, optional pause until all results are out
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;
    bit drain_armed = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_beat  <= '0;
        end else if (!in_valid || !in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (send_queue.size() == 0) begin
                in_valid  <= 1'b0;
                stim_done <= 1'b1;
            end else if (send_queue[0].drain_first && !drain_armed) begin
                // pause first so the closing beat's results are counted
                drain_armed = 1'b1;
                in_valid <= 1'b0;
            end else if (send_queue[0].drain_first && !results_clear) begin
                in_valid <= 1'b0;
            end else begin
                drain_armed = 1'b0;
                in_beat  <= send_queue[0].beat;
                void'(send_queue.pop_front());
                in_valid <= 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall pattern with long hold-offs
    // ------------------------------------------------------------------------
    int results_taken = 0;
    int holds_done = 0;
    int hold_left = 0;
    int phase_left = 0;
    int stall_pct = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (out_valid && ((holds_done == 0 && results_taken >= 40) ||
                                       (holds_done == 1 && results_taken >= 160))) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 30;
                        3: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                phase_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // prediction and checking
    // ------------------------------------------------------------------------
    task automatic add_to_batch(smsort_pkg::t_in_beat beat);
        smsort_pkg::t_out_beat res;
        logic [KEY_BITS-1:0]   k;
        logic [TAG_BITS-1:0]   t;
        int                    j;
        int                    n;
        if (batch_keys.size() < MAX_ITEMS) begin
            batch_keys.push_back(beat.key);
            batch_tags.push_back(beat.tag);
        end else begin
            batch_dropped = 1'b1;
        end
        if (beat.last) begin
            n = batch_keys.size();
            // insertion sort: an entry only moves past strictly greater keys
            for (int i = 1; i < n; i++) begin
                k = batch_keys[i];
                t = batch_tags[i];
                j = i;
                while (j > 0 && batch_keys[j-1] > k) begin
                    batch_keys[j] = batch_keys[j-1];
                    batch_tags[j] = batch_tags[j-1];
                    j--;
                end
                batch_keys[j] = k;
                batch_tags[j] = t;
            end
            for (int i = 0; i < n; i++) begin
                res.sorted_key = batch_keys[i];
                res.sorted_tag = batch_tags[i];
                res.final_res  = (i == n - 1);
                res.overflow   = batch_dropped;
                sorted_results.push_back(res);
            end
            batch_keys.delete();
            batch_tags.delete();
            batch_dropped = 1'b0;
        end
    endtask

    always @(posedge clk) begin
        smsort_pkg::t_out_beat want;
        if (!rst_n) begin
            results_clear <= 1'b1;
        end else begin
            if (out_valid && !out_stall) begin
                if (sorted_results.size() == 0) begin
                    $error("output beat with no result pending: key %h tag %h",
                           out_beat.sorted_key, out_beat.sorted_tag);
                    mismatches++;
                end else begin
                    want = sorted_results.pop_front();
                    if (out_beat.sorted_key !== want.sorted_key) begin
                        $error("sorted_key: expected %h, actual %h",
                               want.sorted_key, out_beat.sorted_key);
                        mismatches++;
                    end
                    if (out_beat.sorted_tag !== want.sorted_tag) begin
                        $error("sorted_tag: expected %h, actual %h",
                               want.sorted_tag, out_beat.sorted_tag);
                        mismatches++;
                    end
                    if (out_beat.final_res !== want.final_res) begin
                        $error("final_res: expected %b, actual %b",
                               want.final_res, out_beat.final_res);
                        mismatches++;
                    end
                    if (out_beat.overflow !== want.overflow) begin
                        $error("overflow: expected %b, actual %b",
                               want.overflow, out_beat.overflow);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall) add_to_batch(in_beat);
            results_clear <= (sorted_results.size() == 0);
        end
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/smsort_pkg.sv
rtl/core/smsort_ram.sv
rtl/core/stable_merge_sort.sv
tb/tb_stable_merge_sort.sv
